FILE: rtl/core/pett_pkg.sv
// Package for the periodic event timer table: sizes, codes, command/status types.
// Used by all modules in rtl/core; depends on nothing.
package pett_pkg;

  localparam int unsigned TableSlots = 8;
  localparam int unsigned SlotW      = $clog2(TableSlots);
  localparam int unsigned CntW       = $clog2(TableSlots + 1);
  localparam logic [31:0] AllOnes    = 32'hFFFF_FFFF;

  // input opcodes
  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;

  // result kinds
  localparam logic [1:0] KindFired  = 2'd0;
  localparam logic [1:0] KindAdd    = 2'd1;
  localparam logic [1:0] KindRemove = 2'd2;
  localparam logic [1:0] KindTick   = 2'd3;

  // config register indexes
  localparam logic [0:0] RegMaxDelay  = 1'b0;
  localparam logic [0:0] RegMaxPeriod = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             load;      // capture input item
    logic             do_add;
    logic             do_remove;
    logic             do_tick;   // advance time, reset scan
    logic             scan_step; // process slot at scan index
    logic             emit_fire; // load output reg with a fired item
    logic             emit_done; // load output reg with final item
  } pett_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]       opcode;
    logic             scan_hit;  // slot at scan index is due
    logic             scan_last; // scan index is the final slot
  } pett_sts_t;

endpackage

FILE: rtl/core/pett_datapath.sv
// Datapath of the timer table: slot storage, time counter, scan unit, output register.
// Depends on pett_pkg.
module pett_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i,
  input  logic [1:0]            opcode_i,
  input  logic [31:0]           delay_i,
  input  logic [31:0]           period_i,
  input  logic [7:0]            slot_i,
  input  pett_pkg::pett_cmd_t   cmd_i,
  output pett_pkg::pett_sts_t   sts_o,
  output logic [1:0]            kind_o,
  output logic [2:0]            slot_index_o,
  output logic                  ok_o,
  output logic [31:0]           next_due_o,
  output logic [3:0]            fired_count_o,
  output logic                  last_o
);

  localparam int unsigned N = pett_pkg::TableSlots;
  localparam int unsigned SW = (pett_pkg::SlotW > 0) ? pett_pkg::SlotW : 1;

  logic [31:0] max_delay_q, max_period_q, now_q;
  logic [N-1:0] active_q, oneshot_q;
  logic [31:0] period_q [N];
  logic [31:0] due_q [N];
  logic [1:0]  op_q;
  logic [31:0] delay_q, per_q;
  logic [7:0]  slot_q;
  logic [SW-1:0] idx_q;
  logic [31:0] earliest_q;
  logic [pett_pkg::CntW-1:0] fired_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_delay_q  <= pett_pkg::AllOnes;
      max_period_q <= pett_pkg::AllOnes;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pett_pkg::RegMaxDelay) max_delay_q <= cfg_data_i;
      else max_period_q <= cfg_data_i;
    end
  end

  // first free slot (used == active in this design)
  logic            free_found;
  logic [SW-1:0]   free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  logic add_ok;
  logic [31:0] eff_delay;
  assign add_ok = !(delay_q > max_delay_q) && !(per_q > max_period_q) && free_found;
  assign eff_delay = (per_q != '0 && delay_q == '0) ? per_q : delay_q;

  logic rem_ok;
  assign rem_ok = ({24'd0, slot_q} < 32'(N));

  // scan slot view
  logic [31:0] cur_due, new_due;
  logic cur_hit;
  assign cur_due = due_q[idx_q];
  assign cur_hit = active_q[idx_q] && (cur_due <= now_q);
  assign new_due = cur_due + period_q[idx_q];

  logic        keep_act;
  logic [31:0] keep_due;
  always_comb begin
    keep_act = active_q[idx_q];
    keep_due = cur_due;
    if (cur_hit) begin
      keep_act = !oneshot_q[idx_q];
      keep_due = new_due;
    end
  end

  assign sts_o.opcode    = op_q;
  assign sts_o.scan_hit  = cur_hit;
  assign sts_o.scan_last = (32'(idx_q) == 32'(N - 1));

  // table and scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q      <= '0;
      active_q   <= '0;
      oneshot_q  <= '0;
      idx_q      <= '0;
      fired_q    <= '0;
      earliest_q <= pett_pkg::AllOnes;
      op_q       <= '0;
    end else begin
      if (cmd_i.load) op_q <= opcode_i;
      if (cmd_i.do_add && add_ok) begin
        active_q[free_idx]  <= 1'b1;
        oneshot_q[free_idx] <= (per_q == '0);
      end
      if (cmd_i.do_remove && rem_ok) begin
        active_q[slot_q[SW-1:0]]  <= 1'b0;
        oneshot_q[slot_q[SW-1:0]] <= 1'b0;
      end
      if (cmd_i.do_tick) begin
        now_q      <= now_q + 32'd1;
        idx_q      <= '0;
        fired_q    <= '0;
        earliest_q <= pett_pkg::AllOnes;
      end
      if (cmd_i.scan_step) begin
        if (cur_hit) begin
          fired_q <= fired_q + 1'b1;
          if (oneshot_q[idx_q]) begin
            active_q[idx_q]  <= 1'b0;
            oneshot_q[idx_q] <= 1'b0;
          end
        end
        if (keep_act && keep_due < earliest_q) earliest_q <= keep_due;
        if (!sts_o.scan_last) idx_q <= idx_q + 1'b1;
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delay_q <= delay_i;
      per_q   <= period_i;
      slot_q  <= slot_i;
    end
    if (cmd_i.do_add && add_ok) begin
      period_q[free_idx] <= per_q;
      due_q[free_idx]    <= now_q + eff_delay;
    end
    if (cmd_i.scan_step && cur_hit) due_q[idx_q] <= new_due;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_fire) begin
      kind_o        <= pett_pkg::KindFired;
      slot_index_o  <= 3'(idx_q);
      ok_o          <= 1'b0;
      next_due_o    <= '0;
      fired_count_o <= '0;
      last_o        <= 1'b0;
    end else if (cmd_i.emit_done) begin
      next_due_o    <= '0;
      fired_count_o <= '0;
      slot_index_o  <= '0;
      ok_o          <= 1'b0;
      last_o        <= 1'b1;
      case (op_q)
        pett_pkg::OpAdd: begin
          kind_o       <= pett_pkg::KindAdd;
          ok_o         <= add_ok;
          slot_index_o <= add_ok ? 3'(free_idx) : 3'd0;
        end
        pett_pkg::OpRemove: begin
          kind_o <= pett_pkg::KindRemove;
          ok_o   <= rem_ok;
        end
        default: begin
          kind_o        <= pett_pkg::KindTick;
          next_due_o    <= earliest_q;
          fired_count_o <= 4'(fired_q);
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/pett_ctrl.sv
// Controller of the timer table: sequences add, remove and the tick scan.
// Depends on pett_pkg.
module pett_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pett_pkg::pett_sts_t sts_i,
  output pett_pkg::pett_cmd_t cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StScan = 3'd2;
  localparam logic [2:0] StDone = 3'd4; // final item waits

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;
  logic       out_free;

  assign out_free    = !ov_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        // wait for output reg free before executing the command
        if (out_free) begin
          case (sts_i.opcode)
            pett_pkg::OpAdd: begin
              cmd_o.emit_done = 1'b1;
              cmd_o.do_add    = 1'b1;
              ov_d            = 1'b1;
              state_d         = StIdle;
            end
            pett_pkg::OpRemove: begin
              cmd_o.emit_done = 1'b1;
              cmd_o.do_remove = 1'b1;
              ov_d            = 1'b1;
              state_d         = StIdle;
            end
            pett_pkg::OpTick: begin
              cmd_o.do_tick = 1'b1;
              state_d       = StScan;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StScan: begin
        if (sts_i.scan_hit) begin
          if (out_free) begin
            cmd_o.emit_fire = 1'b1;
            cmd_o.scan_step = 1'b1;
            ov_d            = 1'b1;
            state_d         = sts_i.scan_last ? StDone : StScan;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = sts_i.scan_last ? StDone : StScan;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.emit_done = 1'b1;
          ov_d            = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

endmodule

FILE: rtl/core/periodic_event_timer_table_unit.sv
// Top level of the periodic event timer table.
// Depends on pett_pkg, pett_ctrl and pett_datapath.
//
// Usage: s_axis carries commands (add, remove, tick), m_axis carries results,
// cfg_* writes the limit registers (index 0 max_delay, index 1 max_period).
// Add and remove give one result item: the command is captured, then executed
// and its result registered once the output register is free; then the unit idles.
// A tick gives one fired item per due slot in slot order, then a tick-done
// item with tlast set. The tick scan walks the eight slots one per cycle
// while the receiver does not hold back a fired item; the tick-done item
// follows the scan, and the next command is taken once it is registered.
// One item is handled at a time; s_axis_tready is high only when idle.
// The output register holds a result until taken; a stalled receiver
// pauses the scan without losing items.
// Reset clears the time counter, every slot, and sets both limits to
// all ones. Opcode 3 is consumed without result.
module periodic_event_timer_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // delay[31:0], period[63:32], slot[71:64], 0
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // slot_index[2:0], ok[3], next_due[35:4],
                                     // fired_count[39:36]
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  pett_pkg::pett_cmd_t cmd;
  pett_pkg::pett_sts_t sts;
  logic [2:0]  slot_index;
  logic        ok;
  logic [31:0] next_due;
  logic [3:0]  fired_count;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {fired_count, next_due, ok, slot_index};

  pett_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pett_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i),
    .cfg_idx_i     (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .opcode_i      (s_axis_tuser),
    .delay_i       (s_axis_tdata[31:0]),
    .period_i      (s_axis_tdata[63:32]),
    .slot_i        (s_axis_tdata[71:64]),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .kind_o        (m_axis_tuser),
    .slot_index_o  (slot_index),
    .ok_o          (ok),
    .next_due_o    (next_due),
    .fired_count_o (fired_count),
    .last_o        (m_axis_tlast)
  );

endmodule

FILE: rtl/core/pett_checker.sv
// Port-level checker for the timer table, bound to the top level.
// Depends on pett_pkg and the periodic_event_timer_table_unit ports.
module pett_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // tlast exactly on non-fired kinds
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != pett_pkg::KindFired)))
    else $error("tlast mismatch with kind");

  // no new command while a result is still being produced
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted two commands back to back");

  // fired items carry no ok flag
  a_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == pett_pkg::KindFired |-> !m_axis_tdata[3])
    else $error("fired item with ok set");

endmodule

bind periodic_event_timer_table_unit pett_checker u_pett_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb.sv
// Testbench for periodic_event_timer_table_unit: queued stimulus, clocked driver and monitor,
// and an in-bench table model that predicts every result item. Depends on pett_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  slot_index;
    logic        ok;
    logic [31:0] next_due;
    logic [3:0]  fired_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [0:0]  index;
    logic [31:0] data;
  } cfg_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic s_axis_tready_q = 1'b0;

  periodic_event_timer_table_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [31:0] lim_delay, lim_period, cur_time;
  logic        t_used [pett_pkg::TableSlots];
  logic        t_active [pett_pkg::TableSlots];
  logic        t_once [pett_pkg::TableSlots];
  logic [31:0] t_period [pett_pkg::TableSlots];
  logic [31:0] t_due [pett_pkg::TableSlots];

  cmd_t pending_cmds[$];
  res_t expected_results[$];
  int   errors = 0;
  int   n_results = 0;
  bit   calm = 0;   // no idling on either side

  function automatic res_t mk(logic [1:0] k, logic [2:0] idx, logic ok,
                              logic [31:0] due, logic [3:0] cnt, logic last);
    res_t r;
    r.kind = k; r.slot_index = idx; r.ok = ok;
    r.next_due = due; r.fired_count = cnt; r.last = last;
    return r;
  endfunction

  function automatic void free_slot(int i);
    t_used[i] = 0; t_active[i] = 0; t_once[i] = 0; t_period[i] = 0; t_due[i] = 0;
  endfunction

  // compute results of one accepted command against the table model
  function automatic void predict_table(cmd_t c);
    logic [31:0] d, earliest;
    int fired;
    bit done;
    d = c.delay; earliest = pett_pkg::AllOnes; fired = 0; done = 0;
    case (c.opcode)
      pett_pkg::OpAdd: begin
        if (c.delay > lim_delay || c.period > lim_period) begin
          expected_results.push_back(mk(pett_pkg::KindAdd, 0, 0, 0, 0, 1));
        end else begin
          for (int i = 0; i < pett_pkg::TableSlots; i++) begin
            if (!done && !t_used[i]) begin
              done = 1;
              t_used[i] = 1;
              if (c.period != 0) begin
                t_once[i] = 0; t_period[i] = c.period;
                if (d == 0) d = c.period;
              end else begin
                t_once[i] = 1; t_period[i] = 0;
              end
              t_due[i] = cur_time + d;
              t_active[i] = 1;
              expected_results.push_back(mk(pett_pkg::KindAdd, i[2:0], 1, 0, 0, 1));
            end
          end
          if (!done) expected_results.push_back(mk(pett_pkg::KindAdd, 0, 0, 0, 0, 1));
        end
      end
      pett_pkg::OpRemove: begin
        if (c.slot < pett_pkg::TableSlots) begin
          free_slot(c.slot);
          expected_results.push_back(mk(pett_pkg::KindRemove, 0, 1, 0, 0, 1));
        end else begin
          expected_results.push_back(mk(pett_pkg::KindRemove, 0, 0, 0, 0, 1));
        end
      end
      pett_pkg::OpTick: begin
        cur_time = cur_time + 1;
        for (int i = 0; i < pett_pkg::TableSlots; i++) begin
          if (t_active[i]) begin
            if (t_due[i] <= cur_time) begin
              expected_results.push_back(mk(pett_pkg::KindFired, i[2:0], 0, 0, 0, 0));
              fired++;
              if (t_once[i]) free_slot(i);
              else t_due[i] = t_due[i] + t_period[i];
            end
            if (t_active[i] && t_due[i] < earliest) earliest = t_due[i];
          end
        end
        expected_results.push_back(mk(pett_pkg::KindTick, 0, 0, earliest, fired[3:0], 1));
      end
      default: ;
    endcase
  endfunction

  // driver: present queued commands at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_q) begin
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_cmds[0].opcode;
        s_axis_tdata  <= {8'h00, pending_cmds[0].slot, pending_cmds[0].period,
                          pending_cmds[0].delay};
      end else if (!(s_axis_tvalid && !s_axis_tready_q)) begin
        s_axis_tvalid <= 1'b0;
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 35);
    end
  end

  // acceptance seen at the rising edge
  always @(posedge clk_i) begin
    s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      predict_table(pending_cmds[0]);
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    res_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mk(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[35:4],
               m_axis_tdata[39:36], m_axis_tlast);
      n_results++;
      if (expected_results.size() == 0) begin
        $error("unexpected result item kind=%0d", got.kind);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got.kind != exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, got.kind); errors++;
        end
        if (got.slot_index != exp_r.slot_index) begin
          $error("slot_index: expected %0d actual %0d", exp_r.slot_index, got.slot_index);
          errors++;
        end
        if (got.ok != exp_r.ok) begin
          $error("ok: expected %0d actual %0d", exp_r.ok, got.ok); errors++;
        end
        if (got.next_due != exp_r.next_due) begin
          $error("next_due: expected %h actual %h", exp_r.next_due, got.next_due); errors++;
        end
        if (got.fired_count != exp_r.fired_count) begin
          $error("fired_count: expected %0d actual %0d", exp_r.fired_count,
                 got.fired_count);
          errors++;
        end
        if (got.last != exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, got.last); errors++;
        end
      end
    end
  end

  task automatic write_limit(logic [0:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == pett_pkg::RegMaxDelay) lim_delay = val; else lim_period = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic cmd_t mkcmd(logic [1:0] op, logic [31:0] d, logic [31:0] p,
                                 logic [7:0] s);
    cmd_t c;
    c.opcode = op; c.delay = d; c.period = p; c.slot = s;
    return c;
  endfunction

  // mostly small delays and periods so events actually fire
  function automatic logic [31:0] rnd_time();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFF0 + $urandom_range(15);
      2: return 0;
      default: return $urandom_range(12);
    endcase
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 35)
        pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, rnd_time(), rnd_time(),
                                     8'($urandom())));
      else if (r < 50)
        pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, $urandom(), $urandom(),
                                     ($urandom_range(3) == 0) ? 8'($urandom()) :
                                                                8'($urandom_range(7))));
      else if (r < 97)
        pending_cmds.push_back(mkcmd(pett_pkg::OpTick, $urandom(), $urandom(),
                                     8'($urandom())));
      else pending_cmds.push_back(mkcmd(OpUnused, $urandom(), $urandom(), 8'($urandom())));
    end
    drain();
  endtask

  initial begin
    lim_delay = pett_pkg::AllOnes; lim_period = pett_pkg::AllOnes; cur_time = 0;
    for (int i = 0; i < pett_pkg::TableSlots; i++) free_slot(i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, overdue, full table, removes, unused opcode
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 0, 0, 0));       // one-shot due now
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 0, 3, 0));       // zero delay periodic
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, pett_pkg::AllOnes, 1, 0)); // maximum delay
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, pett_pkg::AllOnes, pett_pkg::AllOnes,
                                 8'hFF));
    pending_cmds.push_back(mkcmd(pett_pkg::OpTick, 0, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 1, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 2, 2, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 5, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 4, 1, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 9, 9, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 1, 1, 0));       // table full
    pending_cmds.push_back(mkcmd(pett_pkg::OpTick, 0, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpTick, 0, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, 0, 0, 8'd7));
    pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, 0, 0, 8'd7)); // already free
    pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, 0, 0, 8'd8)); // out of range
    pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, pett_pkg::AllOnes, pett_pkg::AllOnes,
                                 8'hFF));
    pending_cmds.push_back(mkcmd(OpUnused, pett_pkg::AllOnes, pett_pkg::AllOnes, 8'hFF));
    pending_cmds.push_back(mkcmd(pett_pkg::OpTick, 0, 0, 0));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(mkcmd(pett_pkg::OpRemove, 0, 0, 8'(i)));
    drain();

    // tight limits: exceeded, equal, zero
    write_limit(pett_pkg::RegMaxDelay, 32'd4);
    write_limit(pett_pkg::RegMaxPeriod, 32'd0);
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 5, 0, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 4, 1, 0));
    pending_cmds.push_back(mkcmd(pett_pkg::OpAdd, 4, 0, 0));
    drain();
    random_phase(20);

    write_limit(pett_pkg::RegMaxDelay, 32'd0);
    write_limit(pett_pkg::RegMaxPeriod, 32'd6);
    random_phase(15);

    write_limit(pett_pkg::RegMaxDelay, pett_pkg::AllOnes);
    write_limit(pett_pkg::RegMaxPeriod, pett_pkg::AllOnes);
    calm = 1;
    random_phase(25);
    calm = 0;
    random_phase(14);

    $display("Ran directed add/remove/tick cases and random traffic under four limit settings,");
    $display("%0d result items checked.", n_results);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/pett_pkg.sv
rtl/core/pett_datapath.sv
rtl/core/pett_ctrl.sv
rtl/core/periodic_event_timer_table_unit.sv
rtl/core/pett_checker.sv
sim/tb.sv
